>>> rtl/cemfm_pkg.sv
`default_nettype none

package cemfm_pkg;

	localparam int unsigned ENERGY_UNIT = 360000;
	localparam int unsigned UNIT_SHIFT  = 6;
	localparam int unsigned UNIT_ODD    = ENERGY_UNIT >> UNIT_SHIFT;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(UNIT_ODD) - 64'd1) / 64'(UNIT_ODD));

	localparam int unsigned REM_W   = 19;
	localparam int unsigned SUM_W   = 25;
	localparam int unsigned T_W     = SUM_W - UNIT_SHIFT;
	localparam int unsigned PROD_W  = T_W + RECIP_W;
	localparam int unsigned QUOT_W  = PROD_W - RECIP_SHIFT;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CNT_W   = 8;

	localparam logic [15:0]      OV_LIMIT_RST  = 16'd2600;
	localparam logic [15:0]      LOW_LIMIT_RST = 16'd1600;
	localparam logic [15:0]      FUSE_LIMIT_RST = 16'd300;
	localparam logic [15:0]      OC_LIMIT_RST  = 16'd6000;
	localparam logic [CNT_W-1:0] TRIP_RST      = 8'd5;

	typedef enum logic [2:0] {
		CFG_OV_LIMIT   = 3'd0,
		CFG_LOW_LIMIT  = 3'd1,
		CFG_FUSE_LIMIT = 3'd2,
		CFG_OC_LIMIT   = 3'd3,
		CFG_TRIP       = 3'd4
	} cfg_index_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [3:0]  outlet;
		logic [15:0] voltage;
		logic [15:0] current;
		logic [23:0] power;
		logic [31:0] saved_energy;
	} sample_t;

	typedef struct packed {
		logic [31:0] energy;
		logic        over_current;
		logic        over_voltage;
		logic        under_voltage;
		logic        fuse_blown;
	} result_t;

	typedef struct packed {
		logic [15:0]      ov_limit;
		logic [15:0]      low_limit;
		logic [15:0]      fuse_limit;
		logic [15:0]      oc_limit;
		logic [CNT_W-1:0] trip;
	} cfg_t;

	typedef struct packed {
		logic [REM_W-1:0] remainder;
		logic [REM_W-1:0] modulus;
		logic [31:0]      quotient;
		logic [31:0]      start_energy;
		logic [31:0]      shown_energy;
		logic [CNT_W-1:0] ov_count;
		logic [CNT_W-1:0] uv_count;
		logic [CNT_W-1:0] fuse_count;
		logic [CNT_W-1:0] oc_count;
		logic             over_current;
		logic             over_voltage;
		logic             under_voltage;
	} entry_t;

	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} stage_en_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
		sat_inc = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/cemfm_state_mem.sv
`default_nettype none

module cemfm_state_mem #(
	parameter int OUTLETS = 2,
	parameter int AW      = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output cemfm_pkg::entry_t      rd_entry,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire cemfm_pkg::entry_t wr_entry
);

	cemfm_pkg::entry_t  mem [OUTLETS];
	logic [OUTLETS-1:0] vld_q;
	cemfm_pkg::entry_t  rd_data_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> rtl/cemfm_monitor.sv
`default_nettype none

module cemfm_monitor (
	input  wire cemfm_pkg::sample_t       sample,
	input  wire cemfm_pkg::entry_t        entry,
	input  wire cemfm_pkg::cfg_t          cfg,
	input  wire logic                     fuse_in,
	output cemfm_pkg::entry_t             entry_next,
	output logic [cemfm_pkg::SUM_W-1:0]   srem,
	output logic                          crossed,
	output logic                          fuse_out
);

	always_comb begin
		logic is_tick;
		is_tick    = (sample.operation == cemfm_pkg::OP_TICK);
		entry_next = entry;
		fuse_out   = fuse_in;
		srem       = cemfm_pkg::SUM_W'(entry.remainder) + cemfm_pkg::SUM_W'(sample.power);
		crossed    = is_tick && (srem >= cemfm_pkg::SUM_W'(cemfm_pkg::ENERGY_UNIT));

		if (!is_tick) begin
			entry_next.start_energy = sample.saved_energy;
			entry_next.shown_energy = sample.saved_energy;
		end else begin
			entry_next.remainder = crossed ? '0 : srem[cemfm_pkg::REM_W-1:0];

			if (sample.voltage >= cfg.ov_limit) begin
				entry_next.ov_count = cemfm_pkg::sat_inc(entry.ov_count);
				if (entry_next.ov_count >= cfg.trip) begin
					entry_next.over_voltage = 1'b1;
				end
			end

			if (sample.voltage <= cfg.low_limit) begin
				entry_next.uv_count = cemfm_pkg::sat_inc(entry.uv_count);
				if (sample.voltage < cfg.fuse_limit) begin
					entry_next.fuse_count = cemfm_pkg::sat_inc(entry.fuse_count);
					if (entry_next.fuse_count >= cfg.trip) begin
						entry_next.under_voltage = 1'b1;
						fuse_out = 1'b1;
					end
				end else begin
					entry_next.uv_count = cemfm_pkg::sat_inc(entry_next.uv_count);
				end
				if (entry_next.uv_count >= cfg.trip) begin
					entry_next.under_voltage = 1'b1;
				end
			end

			if (sample.voltage > cfg.low_limit && sample.voltage < cfg.ov_limit) begin
				entry_next.ov_count      = '0;
				entry_next.uv_count      = '0;
				entry_next.over_voltage  = 1'b0;
				entry_next.under_voltage = 1'b0;
				fuse_out = 1'b0;
			end

			if (sample.current >= cfg.oc_limit) begin
				entry_next.oc_count = cemfm_pkg::sat_inc(entry.oc_count);
				if (entry_next.oc_count >= cfg.trip) begin
					entry_next.over_current = 1'b1;
				end
			end else begin
				entry_next.oc_count     = '0;
				entry_next.over_current = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/cemfm_energy.sv
`default_nettype none

module cemfm_energy (
	input  wire logic                        clk,
	input  wire cemfm_pkg::stage_en_t        en,
	input  wire cemfm_pkg::entry_t           entry_s1,
	input  wire logic [cemfm_pkg::SUM_W-1:0] srem_s1,
	input  wire logic                        cross_s1,
	output cemfm_pkg::entry_t                entry_out
);

	cemfm_pkg::entry_t                 entry_s2, entry_s3, entry_s4;
	logic [cemfm_pkg::SUM_W-1:0]       srem_s2, sum_s3;
	logic [cemfm_pkg::PROD_W-1:0]      prod_s3;
	logic                              cross_s2, cross_s3, cross_s4;

	logic [cemfm_pkg::SUM_W-1:0]       sum;
	logic [cemfm_pkg::PROD_W-1:0]      prod;
	logic [cemfm_pkg::QUOT_W-1:0]      dq;
	logic [cemfm_pkg::SUM_W-1:0]       mod_new;
	cemfm_pkg::entry_t                 entry_div;

	assign sum  = cemfm_pkg::SUM_W'(entry_s2.modulus) + srem_s2;
	assign prod = cemfm_pkg::PROD_W'(sum[cemfm_pkg::SUM_W-1:cemfm_pkg::UNIT_SHIFT])
		* cemfm_pkg::PROD_W'(cemfm_pkg::RECIP);

	assign dq      = prod_s3[cemfm_pkg::PROD_W-1:cemfm_pkg::RECIP_SHIFT];
	assign mod_new = sum_s3 - cemfm_pkg::SUM_W'(cemfm_pkg::SUM_W'(dq)
		* cemfm_pkg::SUM_W'(cemfm_pkg::ENERGY_UNIT));

	always_comb begin
		entry_div = entry_s3;
		if (cross_s3) begin
			entry_div.modulus  = mod_new[cemfm_pkg::REM_W-1:0];
			entry_div.quotient = entry_s3.quotient + 32'(dq);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			entry_s2 <= entry_s1;
			srem_s2  <= srem_s1;
			cross_s2 <= cross_s1;
		end
		if (en.ld3) begin
			entry_s3 <= entry_s2;
			sum_s3   <= sum;
			prod_s3  <= prod;
			cross_s3 <= cross_s2;
		end
		if (en.ld4) begin
			entry_s4 <= entry_div;
			cross_s4 <= cross_s3;
		end
	end

	always_comb begin
		entry_out = entry_s4;
		if (cross_s4) begin
			entry_out.shown_energy = entry_s4.start_energy + entry_s4.quotient;
		end
	end

endmodule

`default_nettype wire

>>> rtl/charger_energy_meter_fault_monitor_core.sv
// Pipeline steps from sample transfer to result valid: memory read and fault update,
// energy sum and reciprocal multiply, quotient and modulus, shown energy and write-back.
// Throughput: one item per cycle while result_stall is low and any five consecutive
// transfers name different outlets; an item for an outlet still in flight waits for
// its write-back, so one outlet alone has only one item in flight at a time.
// Reset clears all outlet state through per-entry valid bits and restores the limits.
`default_nettype none

module charger_energy_meter_fault_monitor_core #(
	parameter int OUTLETS = 2
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [cemfm_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      sample_valid,
	output logic                           sample_stall,
	input  wire cemfm_pkg::sample_t        sample,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output cemfm_pkg::result_t             result
);

	localparam int AW = (OUTLETS > 1) ? $clog2(OUTLETS) : 1;

	cemfm_pkg::cfg_t      cfg_q;
	logic                 fuse_q;

	cemfm_pkg::sample_t   smp_s1;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 inr_s1, inr_s2, inr_s3, inr_s4;
	logic [3:0]           outlet_s2, outlet_s3, outlet_s4;
	logic                 fuse_s2, fuse_s3, fuse_s4;
	logic                 out_v_q;
	cemfm_pkg::result_t   result_q;

	logic                 ld1, ld2, ld3, ld4, ld_out;
	logic                 hazard, sample_in_range, accept;
	cemfm_pkg::stage_en_t en;

	cemfm_pkg::entry_t    rd_entry, entry_s1, entry_out;
	logic [cemfm_pkg::SUM_W-1:0] srem_s1;
	logic                 cross_s1, fuse_next;
	logic                 wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ov_limit   <= cemfm_pkg::OV_LIMIT_RST;
			cfg_q.low_limit  <= cemfm_pkg::LOW_LIMIT_RST;
			cfg_q.fuse_limit <= cemfm_pkg::FUSE_LIMIT_RST;
			cfg_q.oc_limit   <= cemfm_pkg::OC_LIMIT_RST;
			cfg_q.trip       <= cemfm_pkg::TRIP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cemfm_pkg::CFG_OV_LIMIT:   cfg_q.ov_limit   <= cfg_data;
				cemfm_pkg::CFG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_data;
				cemfm_pkg::CFG_FUSE_LIMIT: cfg_q.fuse_limit <= cfg_data;
				cemfm_pkg::CFG_OC_LIMIT:   cfg_q.oc_limit   <= cfg_data;
				cemfm_pkg::CFG_TRIP:       cfg_q.trip       <= cfg_data[cemfm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign ld_out = !out_v_q || !result_stall;
	assign ld4    = !v_s4 || ld_out;
	assign ld3    = !v_s3 || ld4;
	assign ld2    = !v_s2 || ld3;
	assign ld1    = !v_s1 || ld2;

	assign en = {ld2, ld3, ld4};

	assign sample_in_range = 5'(sample.outlet) < 5'(OUTLETS);

	// hold a transfer while its outlet is still in flight
	assign hazard = (v_s1 && inr_s1 && smp_s1.outlet == sample.outlet)
		|| (v_s2 && inr_s2 && outlet_s2 == sample.outlet)
		|| (v_s3 && inr_s3 && outlet_s3 == sample.outlet)
		|| (v_s4 && inr_s4 && outlet_s4 == sample.outlet);

	assign sample_stall = !ld1 || hazard;
	assign accept       = sample_valid && !sample_stall;

	assign wr_en = v_s4 && inr_s4 && ld_out;

	cemfm_state_mem #(
		.OUTLETS (OUTLETS),
		.AW      (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (sample.outlet[AW-1:0]),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (outlet_s4[AW-1:0]),
		.wr_entry (entry_out)
	);

	cemfm_monitor u_monitor (
		.sample     (smp_s1),
		.entry      (rd_entry),
		.cfg        (cfg_q),
		.fuse_in    (fuse_q),
		.entry_next (entry_s1),
		.srem       (srem_s1),
		.crossed    (cross_s1),
		.fuse_out   (fuse_next)
	);

	cemfm_energy u_energy (
		.clk       (clk),
		.en        (en),
		.entry_s1  (entry_s1),
		.srem_s1   (srem_s1),
		.cross_s1  (cross_s1),
		.entry_out (entry_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			fuse_q  <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= accept;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
			if (ld_out) begin
				out_v_q <= v_s4;
			end
			if (v_s1 && ld2 && inr_s1) begin
				fuse_q <= fuse_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= sample;
			inr_s1 <= sample_in_range;
		end
		if (ld2) begin
			inr_s2    <= inr_s1;
			outlet_s2 <= smp_s1.outlet;
			fuse_s2   <= inr_s1 ? fuse_next : fuse_q;
		end
		if (ld3) begin
			inr_s3    <= inr_s2;
			outlet_s3 <= outlet_s2;
			fuse_s3   <= fuse_s2;
		end
		if (ld4) begin
			inr_s4    <= inr_s3;
			outlet_s4 <= outlet_s3;
			fuse_s4   <= fuse_s3;
		end
		if (ld_out) begin
			result_q.energy        <= inr_s4 ? entry_out.shown_energy : '0;
			result_q.over_current  <= inr_s4 && entry_out.over_current;
			result_q.over_voltage  <= inr_s4 && entry_out.over_voltage;
			result_q.under_voltage <= inr_s4 && entry_out.under_voltage;
			result_q.fuse_blown    <= fuse_s4;
		end
	end

	assign result_valid = out_v_q;
	assign result       = result_q;

endmodule

`default_nettype wire
